FILE: rtl/core/rau_pkg.sv
// package for the rational arithmetic unit: operation codes, widths, packed types
// no dependencies
package rau_pkg;
    localparam int WordWidth = 32;
    localparam int CfgWidth  = 31;
    localparam logic [CfgWidth-1:0] NormThresholdReset = 31'd126;
    localparam logic [CfgWidth-1:0] ReduceLimitReset   = 31'd16385;

    typedef enum logic [3:0] {
        KIND_CONSTRUCT = 4'd0,
        KIND_NORMALIZE = 4'd1,
        KIND_ADD       = 4'd2,
        KIND_SUB       = 4'd3,
        KIND_MUL       = 4'd4,
        KIND_DIV       = 4'd5,
        KIND_NEG       = 4'd6,
        KIND_INV       = 4'd7,
        KIND_REDUCE    = 4'd8,
        KIND_COMPARE   = 4'd9,
        KIND_INTPART   = 4'd10,
        KIND_FIXED     = 4'd11
    } kind_t;

    localparam logic [1:0] ADDR_NORM_THRESHOLD = 2'd0;
    localparam logic [1:0] ADDR_REDUCE_LIMIT   = 2'd1;

    // divider request and response
    typedef struct packed {
        logic                 start;
        logic [WordWidth-1:0] dividend;
        logic [WordWidth-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [WordWidth-1:0] quotient;
    } div_rsp_t;

    function automatic logic [WordWidth-1:0] mag(input logic [WordWidth-1:0] x);
        mag = x[WordWidth-1] ? (~x + 1'b1) : x;
    endfunction
endpackage

FILE: rtl/core/rational_arithmetic_unit.sv
// top level of the rational arithmetic unit: stream ports, apb registers, result register
// depends on rau_pkg and rau_sequencer
//
// One request at a time. s_tready is high only while the unit is idle; a request
// uses the shared multiplier, binary gcd steps and calls of the bit-serial divider
// (a full gcd reduction divides twice, reduce up to six times, intpart and
// fixedpoint once). The result is held in an output register until taken; a new
// request is accepted once the unit has returned to idle and the output register
// is empty.
// Registers: 0 norm_threshold, 1 reduce_limit at byte addresses 0 and 4.
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,   // a_num, a_den, b_num, b_den, scale
    input  logic [3:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // res_num, res_den, order, equal, scalar_value, is_error, inexact, pad
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    logic [CfgWidth-1:0] thr_reg, lim_reg;
    logic                busy_reg;
    logic                out_valid_reg;
    logic [100:0]        out_data_reg;
    logic                done, equal, is_error, inexact;
    logic [31:0]         res_num, res_den, scalar_value;
    logic [1:0]          order;
    logic                start;
    logic [1:0]          reg_index;

    // registers sit at byte addresses 0 and 4
    assign reg_index = {1'b0, paddr[2]};

    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= NormThresholdReset;
            lim_reg <= ReduceLimitReset;
        end
        else if (psel && penable && pwrite)
        begin
            if (reg_index == ADDR_NORM_THRESHOLD) thr_reg <= pwdata[CfgWidth-1:0];
            else if (reg_index == ADDR_REDUCE_LIMIT) lim_reg <= pwdata[CfgWidth-1:0];
        end
    end
    assign prdata = (reg_index == ADDR_NORM_THRESHOLD) ? {1'b0, thr_reg} :
                    (reg_index == ADDR_REDUCE_LIMIT) ? {1'b0, lim_reg} : 32'd0;

    // idle once no request is in flight and the output register is free
    assign s_tready = !busy_reg && !out_valid_reg;
    assign start    = s_tvalid && s_tready;

    rau_sequencer u_seq (
        .clk(clk), .rst_n(rst_n), .start(start), .kind(s_tuser),
        .a_num(s_tdata[31:0]), .a_den(s_tdata[63:32]), .b_num(s_tdata[95:64]),
        .b_den(s_tdata[127:96]), .scale(s_tdata[159:128]),
        .norm_threshold(thr_reg), .reduce_limit(lim_reg),
        .done(done), .res_num(res_num), .res_den(res_den), .order(order),
        .equal(equal), .scalar_value(scalar_value), .is_error(is_error), .inexact(inexact)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (start) busy_reg <= 1'b1;
            else if (done) busy_reg <= 1'b0;
            if (done) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
            out_data_reg <= {inexact, is_error, scalar_value, equal, order, res_den, res_num};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_data_reg};

    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !s_tready) else $error("second request taken");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy_reg) else $error("result without request");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
endmodule

FILE: rtl/core/rau_divider.sv
// unsigned restoring divider, one quotient bit a cycle
// depends on rau_pkg
module rau_divider
    import rau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    localparam int CntWidth = $clog2(WordWidth + 1);

    logic [WordWidth-1:0] rem_reg, rem_next;
    logic [WordWidth-1:0] quo_reg, quo_next;
    logic [WordWidth-1:0] dsr_reg, dsr_next;
    logic [CntWidth-1:0]  cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [WordWidth:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[WordWidth-1]} - {1'b0, dsr_reg};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = CntWidth'(WordWidth);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[WordWidth])
            begin
                rem_next = trial[WordWidth-1:0];
                quo_next = {quo_reg[WordWidth-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[WordWidth-2:0], quo_reg[WordWidth-1]};
                quo_next = {quo_reg[WordWidth-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntWidth'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("divider done while busy");
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy_reg && !req.start) |=> !busy_reg) else $error("divider woke alone");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg) else $error("divider missed start");
endmodule

FILE: rtl/core/rau_sequencer.sv
// operation sequencer: products, binary gcd steps and divider calls
// depends on rau_pkg and rau_divider
module rau_sequencer
    import rau_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [3:0]            kind,
    input  logic [WordWidth-1:0]  a_num,
    input  logic [WordWidth-1:0]  a_den,
    input  logic [WordWidth-1:0]  b_num,
    input  logic [WordWidth-1:0]  b_den,
    input  logic [WordWidth-1:0]  scale,
    input  logic [CfgWidth-1:0]   norm_threshold,
    input  logic [CfgWidth-1:0]   reduce_limit,
    output logic                  done,
    output logic [WordWidth-1:0]  res_num,
    output logic [WordWidth-1:0]  res_den,
    output logic [1:0]            order,
    output logic                  equal,
    output logic [WordWidth-1:0]  scalar_value,
    output logic                  is_error,
    output logic                  inexact
);
    localparam int TzWidth = $clog2(WordWidth);

    typedef enum logic [4:0] {
        S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_PREP, S_OPT,
        S_G_INIT, S_G_SHA, S_G_LOOP, S_G_SUB, S_G_FIN,
        S_D_P, S_D_PW, S_D_Q, S_D_QW,
        S_R_P, S_R_PW, S_R_Q, S_R_QW, S_R_M, S_R_MP, S_R_MPW, S_R_MQ, S_R_MQW,
        S_SC, S_SCW, S_DONE
    } state_t;

    state_t               state_reg;
    logic [3:0]           kind_reg;
    logic [WordWidth-1:0] ap_reg, aq_reg, bp_reg, bq_reg, sc_reg;
    logic [WordWidth-1:0] x_reg;
    logic [WordWidth-1:0] rp_reg, rq_reg;
    logic [WordWidth-1:0] ga_reg, gb_reg;
    logic [TzWidth-1:0]   k_reg;
    logic [WordWidth-1:0] mp_reg, m_reg;
    logic [WordWidth-1:0] sv_reg;
    logic [1:0]           ord_reg;
    logic                 eq_reg, err_reg, inx_reg;
    logic                 neg_reg;

    logic [WordWidth-1:0] mul_a, mul_b, mul_p;
    logic [WordWidth-1:0] lim;
    logic [WordWidth-1:0] thr;
    div_req_t             dreq;
    div_rsp_t             drsp;
    logic [WordWidth-1:0] dq_signed;

    rau_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // trailing zero count of a nonzero word
    function automatic logic [TzWidth-1:0] tzc(input logic [WordWidth-1:0] x);
        logic [TzWidth-1:0] r;
        r = '0;
        for (int i = WordWidth - 1; i >= 0; i--)
            if (x[i]) r = TzWidth'(i);
        return r;
    endfunction

    // one shared multiplier, operands chosen by state
    always_comb
    begin
        mul_a = ap_reg;
        mul_b = bq_reg;
        unique case (state_reg)
            S_MUL1:
            begin
                unique case (kind_reg)
                    KIND_MUL:   begin mul_a = ap_reg; mul_b = bp_reg; end
                    KIND_FIXED: begin mul_a = ap_reg; mul_b = sc_reg; end
                    default:    begin mul_a = ap_reg; mul_b = bq_reg; end
                endcase
            end
            S_MUL2:
            begin
                unique case (kind_reg)
                    KIND_MUL, KIND_ADD, KIND_SUB: begin mul_a = aq_reg; mul_b = bq_reg; end
                    KIND_DIV:   begin mul_a = aq_reg; mul_b = bp_reg; end
                    default:    begin mul_a = aq_reg; mul_b = bp_reg; end
                endcase
            end
            // second cross product of add and sub
            S_MUL3:
            begin
                mul_a = aq_reg;
                mul_b = bp_reg;
            end
            default: ;
        endcase
    end
    assign mul_p = WordWidth'(mul_a * mul_b);

    assign lim = (reduce_limit == '0) ? WordWidth'(1) : WordWidth'(reduce_limit);
    assign thr = WordWidth'(norm_threshold);
    assign dq_signed = neg_reg ? (~drsp.quotient + 1'b1) : drsp.quotient;

    always_comb
    begin
        dreq.start    = 1'b0;
        dreq.dividend = '0;
        dreq.divisor  = WordWidth'(1);
        unique case (state_reg)
            S_D_P:  begin dreq.start = 1'b1; dreq.dividend = mag(rp_reg); dreq.divisor = ga_reg; end
            S_D_Q:  begin dreq.start = 1'b1; dreq.dividend = mag(rq_reg); dreq.divisor = ga_reg; end
            S_R_P:  begin dreq.start = 1'b1; dreq.dividend = mag(ap_reg); dreq.divisor = lim; end
            S_R_Q:  begin dreq.start = 1'b1; dreq.dividend = mag(aq_reg); dreq.divisor = lim; end
            S_R_MP: begin dreq.start = 1'b1; dreq.dividend = mag(rp_reg); dreq.divisor = mag(m_reg); end
            S_R_MQ: begin dreq.start = 1'b1; dreq.dividend = mag(rq_reg); dreq.divisor = mag(m_reg); end
            S_SC:   begin dreq.start = 1'b1; dreq.dividend = mag(x_reg);  dreq.divisor = mag(aq_reg); end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            inx_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        kind_reg <= kind;
                        ap_reg <= a_num; aq_reg <= a_den;
                        bp_reg <= b_num; bq_reg <= b_den;
                        sc_reg <= scale;
                        rp_reg <= '0; rq_reg <= WordWidth'(1);
                        ord_reg <= '0; eq_reg <= 1'b0; sv_reg <= '0; err_reg <= 1'b0;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    unique case (kind_reg)
                        KIND_CONSTRUCT: begin rp_reg <= ap_reg; rq_reg <= aq_reg; state_reg <= S_OPT; end
                        KIND_NORMALIZE: begin rp_reg <= ap_reg; rq_reg <= aq_reg; state_reg <= S_G_INIT; end
                        KIND_NEG: begin rp_reg <= ~ap_reg + 1'b1; rq_reg <= aq_reg; state_reg <= S_OPT; end
                        KIND_INV:
                        begin
                            if (ap_reg == '0)
                            begin
                                rp_reg <= WordWidth'(1); rq_reg <= '0; state_reg <= S_DONE;
                            end
                            else
                            begin
                                rp_reg <= aq_reg; rq_reg <= ap_reg; state_reg <= S_OPT;
                            end
                        end
                        KIND_REDUCE: state_reg <= S_R_P;
                        KIND_INTPART:
                        begin
                            x_reg <= ap_reg;
                            if (aq_reg == '0) begin err_reg <= 1'b1; state_reg <= S_DONE; end
                            else state_reg <= S_SC;
                        end
                        KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV, KIND_COMPARE, KIND_FIXED:
                            state_reg <= S_MUL1;
                        default: state_reg <= S_DONE;
                    endcase
                end
                S_MUL1:
                begin
                    x_reg <= mul_p;
                    if (kind_reg == KIND_FIXED)
                    begin
                        if (aq_reg == '0) begin err_reg <= 1'b1; state_reg <= S_DONE; end
                        else state_reg <= S_SC;
                    end
                    else state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    unique case (kind_reg)
                        KIND_ADD, KIND_SUB: begin rq_reg <= mul_p; state_reg <= S_MUL3; end
                        KIND_MUL, KIND_DIV: begin rp_reg <= x_reg; rq_reg <= mul_p; state_reg <= S_OPT; end
                        default:
                        begin
                            ord_reg <= ((x_reg - mul_p) == '0) ? 2'd0 :
                                       ((x_reg - mul_p) >> (WordWidth - 1)) != '0 ? 2'd3 : 2'd1;
                            eq_reg <= (x_reg == mul_p);
                            err_reg <= (aq_reg == '0) || (bq_reg == '0);
                            rp_reg <= '0; rq_reg <= WordWidth'(1);
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_MUL3:
                begin
                    if (kind_reg == KIND_SUB) rp_reg <= x_reg - mul_p;
                    else rp_reg <= x_reg + mul_p;
                    state_reg <= S_OPT;
                end
                S_OPT:
                begin
                    if (rq_reg[WordWidth-1])
                    begin
                        rp_reg <= ~rp_reg + 1'b1;
                        rq_reg <= ~rq_reg + 1'b1;
                    end
                    // the sign move leaves both magnitudes as they are
                    if (mag(rp_reg) > thr || mag(rq_reg) > thr)
                        state_reg <= S_G_INIT;
                    else
                        state_reg <= S_DONE;
                end
                S_G_INIT:
                begin
                    ga_reg <= (rp_reg == '0) ? mag(rq_reg) : mag(rp_reg);
                    gb_reg <= mag(rq_reg);
                    k_reg  <= tzc(mag(rp_reg) | mag(rq_reg));
                    if (rp_reg == '0)
                        state_reg <= (rq_reg == '0) ? S_DONE : S_D_P;
                    else state_reg <= S_G_SHA;
                end
                S_G_SHA:
                begin
                    ga_reg <= ga_reg >> tzc(ga_reg);
                    state_reg <= S_G_LOOP;
                end
                S_G_LOOP:
                begin
                    if (gb_reg == '0) state_reg <= S_G_FIN;
                    else
                    begin
                        gb_reg <= gb_reg >> tzc(gb_reg);
                        state_reg <= S_G_SUB;
                    end
                end
                S_G_SUB:
                begin
                    if (ga_reg > gb_reg)
                    begin
                        ga_reg <= gb_reg;
                        gb_reg <= ga_reg - gb_reg;
                    end
                    else gb_reg <= gb_reg - ga_reg;
                    state_reg <= S_G_LOOP;
                end
                S_G_FIN:
                begin
                    ga_reg <= ga_reg << k_reg;
                    state_reg <= S_D_P;
                end
                S_D_P:  begin neg_reg <= rp_reg[WordWidth-1]; state_reg <= S_D_PW; end
                S_D_PW: if (drsp.done) begin rp_reg <= dq_signed; state_reg <= S_D_Q; end
                S_D_Q:  begin neg_reg <= rq_reg[WordWidth-1]; state_reg <= S_D_QW; end
                S_D_QW: if (drsp.done) begin rq_reg <= dq_signed; state_reg <= S_DONE; end
                S_R_P:  begin neg_reg <= ap_reg[WordWidth-1]; state_reg <= S_R_PW; end
                S_R_PW: if (drsp.done) begin mp_reg <= dq_signed; state_reg <= S_R_Q; end
                S_R_Q:  begin neg_reg <= aq_reg[WordWidth-1]; state_reg <= S_R_QW; end
                S_R_QW:
                if (drsp.done)
                begin
                    m_reg <= ($signed(dq_signed) < $signed(mp_reg)) ? mp_reg : dq_signed;
                    rp_reg <= ap_reg; rq_reg <= aq_reg;
                    state_reg <= S_R_M;
                end
                S_R_M:
                begin
                    if ($signed(m_reg) > $signed(WordWidth'(1)))
                    begin
                        inx_reg <= 1'b1;
                        state_reg <= S_R_MP;
                    end
                    else state_reg <= S_G_INIT;
                end
                S_R_MP:  begin neg_reg <= rp_reg[WordWidth-1]; state_reg <= S_R_MPW; end
                S_R_MPW: if (drsp.done) begin rp_reg <= dq_signed; state_reg <= S_R_MQ; end
                S_R_MQ:  begin neg_reg <= rq_reg[WordWidth-1]; state_reg <= S_R_MQW; end
                S_R_MQW: if (drsp.done) begin rq_reg <= dq_signed; state_reg <= S_G_INIT; end
                S_SC:    begin neg_reg <= x_reg[WordWidth-1] ^ aq_reg[WordWidth-1]; state_reg <= S_SCW; end
                S_SCW:   if (drsp.done) begin sv_reg <= dq_signed; state_reg <= S_DONE; end
                S_DONE:
                begin
                    if (kind_reg <= KIND_REDUCE) err_reg <= (rq_reg == '0);
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // done pulses in the cycle after S_DONE so err_reg has settled
    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) done_reg <= 1'b0;
        else        done_reg <= (state_reg == S_DONE);
    end

    assign done         = done_reg;
    assign res_num      = rp_reg;
    assign res_den      = rq_reg;
    assign order        = ord_reg;
    assign equal        = eq_reg;
    assign scalar_value = sv_reg;
    assign is_error     = err_reg;
    assign inexact      = inx_reg;

    a_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && state_reg != S_IDLE) |-> 1'b0) else $error("request while busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE) else $error("done outside idle");
    a_inexact_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(inx_reg) |-> inx_reg) else $error("inexact flag cleared");
endmodule
